// File: rtl/core/m3i_pkg.sv
`timescale 1ns / 1ps

package m3i_pkg;

  localparam int unsigned ELEM_W        = 32;  // one matrix element, signed fixed point
  localparam int unsigned N_ELEM        = 9;
  localparam int unsigned DATA_W        = ELEM_W * N_ELEM;
  localparam int unsigned THR_W         = 31;  // singularity threshold width
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned PROD_W        = 2 * ELEM_W;      // a*b
  localparam int unsigned COF_W         = PROD_W + 1;      // a*b - c*d
  localparam int unsigned DET_W         = 97;              // sum of three a*C terms
  localparam int unsigned QUOT_BITS     = ELEM_W + 2;      // result bits plus round bit plus sign room

  typedef logic signed [ELEM_W-1:0] elem_t;

  localparam elem_t SAT_POS = 32'sh7FFF_FFFF;
  localparam elem_t SAT_NEG = 32'sh8000_0000;

endpackage

// File: rtl/core/matrix3x3_inverse_unit.sv
`timescale 1ns / 1ps

// 3x3 matrix inverse, signed fixed point with FRAC_BITS fraction bits.
// Input stream s_axis_*: one word per matrix, nine elements in row-major order.
// Output stream m_axis_*: one word per matrix, the inverse in row-major order;
//   m_axis_tuser flags a singular matrix (|det| at or below the threshold),
//   in which case all nine elements are zero.
// Configuration: cfg_wr_en/cfg_wr_data write the singularity threshold
//   (fixed-point LSBs). Write it only while the pipeline is empty.
// Datapath: cofactors and determinant in six stages (32x33 multipliers at
//   most), then nine restoring dividers, one quotient bit per stage over 34
//   stages, then rounding and saturation.
// Throughput: one matrix per cycle while the skid register is empty.
// Stall: the pipeline advances while the skid register is empty. When the
//   receiver holds m_axis_tready low, one more word lands in the skid register
//   and then s_axis_tready drops; nothing is lost or repeated.
// Reset (rst, synchronous): empties the pipeline and the output, and clears
//   the threshold to zero (any |det| below one LSB then counts as singular).
module matrix3x3_inverse_unit #(
  parameter int unsigned FRAC_BITS = m3i_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [m3i_pkg::THR_W-1:0]    cfg_wr_data,   // min_det_magnitude
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [m3i_pkg::DATA_W-1:0]   s_axis_tdata,  // a_00,a_01,a_02,a_10,..,a_22
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [m3i_pkg::DATA_W-1:0]   m_axis_tdata,  // inv_00,inv_01,..,inv_22
  output logic                         m_axis_tuser   // singular
);

  localparam int unsigned EW  = m3i_pkg::ELEM_W;
  localparam int unsigned PW  = m3i_pkg::PROD_W;
  localparam int unsigned CW  = m3i_pkg::COF_W;
  localparam int unsigned DW  = m3i_pkg::DET_W;
  localparam int unsigned AW  = DW - 1;            // |det|
  localparam int unsigned RW  = DW;                // divider remainder
  localparam int unsigned QB  = m3i_pkg::QUOT_BITS;
  localparam int unsigned SH  = 2 * FRAC_BITS;
  localparam int unsigned XW  = PW + SH + 1;       // |C| << (2F+1)
  localparam int unsigned DW_DATA = m3i_pkg::DATA_W;

  // cofactor j = a[s0]*a[s1] - a[s2]*a[s3], row-major element numbers
  localparam int unsigned COF_SEL [9][4] = '{
    '{4, 8, 5, 7}, '{2, 7, 1, 8}, '{1, 5, 2, 4},
    '{5, 6, 3, 8}, '{0, 8, 2, 6}, '{2, 3, 0, 5},
    '{3, 7, 4, 6}, '{1, 6, 0, 7}, '{0, 4, 1, 3}
  };

  logic [m3i_pkg::THR_W-1:0] min_det_magnitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_det_magnitude <= '0;
    end else if (cfg_wr_en) begin
      min_det_magnitude <= cfg_wr_data;
    end
  end

  // pipeline advances while the skid register is empty
  logic en;
  logic skid_valid;
  assign en = !skid_valid;
  assign s_axis_tready = en;

  // stage registers
  logic v0, v1, v2, v3, v4, v5, v6, vfin;
  m3i_pkg::elem_t       a0  [0:8];
  logic signed [PW-1:0] pp1 [0:17];
  m3i_pkg::elem_t       r1  [0:2];
  m3i_pkg::elem_t       r2  [0:2];
  logic signed [CW-1:0] cof2 [0:8];
  logic signed [CW-1:0] cof3 [0:8];
  logic signed [CW-1:0] cof4 [0:8];
  logic signed [CW-1:0] cof5 [0:8];
  logic signed [CW:0]   pl3 [0:2];
  logic signed [CW:0]   ph3 [0:2];
  logic signed [DW-1:0] tm4 [0:2];
  logic signed [DW-1:0] det5;
  logic [AW-1:0]        ad6;
  logic                 dneg6;
  logic [CW-2:0]        ac6 [0:8];
  logic [8:0]           cn6;

  // divider stages
  logic [RW-1:0] dv_rem [0:QB][0:8];
  logic [QB-1:0] dv_xl  [0:QB][0:8];
  logic [QB-1:0] dv_q   [0:QB][0:8];
  logic [AW-1:0] dv_ad  [0:QB];
  logic [8:0]    dv_neg [0:QB];
  logic [8:0]    dv_ovf [0:QB];
  logic          dv_sing[0:QB];
  logic          dv_vld [0:QB];

  logic [DW_DATA-1:0] fin_data;
  logic               fin_sing;

  logic [DW_DATA-1:0] skid_data;
  logic               skid_sing;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0;
      v4 <= 1'b0; v5 <= 1'b0; v6 <= 1'b0; vfin <= 1'b0;
      dv_vld[0] <= 1'b0;
    end else if (en) begin
      v0 <= s_axis_tvalid;
      v1 <= v0; v2 <= v1; v3 <= v2; v4 <= v3; v5 <= v4; v6 <= v5;
      dv_vld[0] <= v6;
      vfin <= dv_vld[QB];
    end
  end

  // cofactors and determinant
  logic [XW-1:0] xv [0:8];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      xv[j] = {ac6[j], {(SH+1){1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        a0[i] <= s_axis_tdata[i*EW +: EW];
      end
      for (int j = 0; j < 9; j++) begin
        pp1[2*j]   <= a0[COF_SEL[j][0]] * a0[COF_SEL[j][1]];
        pp1[2*j+1] <= a0[COF_SEL[j][2]] * a0[COF_SEL[j][3]];
      end
      for (int t = 0; t < 3; t++) begin
        r1[t] <= a0[t];
        r2[t] <= r1[t];
      end
      for (int j = 0; j < 9; j++) begin
        cof2[j] <= CW'(pp1[2*j]) - CW'(pp1[2*j+1]);
        cof3[j] <= cof2[j];
        cof4[j] <= cof3[j];
        cof5[j] <= cof4[j];
      end
      // det = a00*C0 + a01*C3 + a02*C6, each C split into hi and lo halves
      for (int t = 0; t < 3; t++) begin
        pl3[t] <= r2[t] * $signed({1'b0, cof2[3*t][EW-1:0]});
        ph3[t] <= r2[t] * $signed(cof2[3*t][CW-1:EW]);
        tm4[t] <= (DW'(ph3[t]) <<< EW) + DW'(pl3[t]);
      end
      det5  <= tm4[0] + tm4[1] + tm4[2];
      dneg6 <= det5[DW-1];
      ad6   <= det5[DW-1] ? AW'(-det5) : AW'(det5);
      for (int j = 0; j < 9; j++) begin
        cn6[j] <= cof5[j][CW-1];
        ac6[j] <= cof5[j][CW-1] ? (CW-1)'(-cof5[j]) : (CW-1)'(cof5[j]);
      end
      // divider entry: high part of the dividend, overflow and singular tests
      dv_ad[0]   <= ad6;
      dv_sing[0] <= (ad6 >> SH) <= AW'(min_det_magnitude);
      for (int j = 0; j < 9; j++) begin
        dv_rem[0][j] <= RW'(xv[j][XW-1:QB]);
        dv_xl[0][j]  <= xv[j][QB-1:0];
        dv_q[0][j]   <= '0;
        dv_ovf[0][j] <= RW'(xv[j][XW-1:QB]) >= RW'(ad6);
        dv_neg[0][j] <= cn6[j] ^ dneg6;
      end
    end
  end

  // restoring division, one quotient bit per stage
  for (genvar k = 0; k < QB; k++) begin : g_div
    logic [RW-1:0] trial [0:8];

    always_comb begin
      for (int j = 0; j < 9; j++) begin
        trial[j] = {dv_rem[k][j][RW-2:0], dv_xl[k][j][QB-1]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[k+1] <= 1'b0;
      end else if (en) begin
        dv_vld[k+1] <= dv_vld[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_ad[k+1]   <= dv_ad[k];
        dv_neg[k+1]  <= dv_neg[k];
        dv_ovf[k+1]  <= dv_ovf[k];
        dv_sing[k+1] <= dv_sing[k];
        for (int j = 0; j < 9; j++) begin
          dv_xl[k+1][j] <= {dv_xl[k][j][QB-2:0], 1'b0};
          if (trial[j] >= RW'(dv_ad[k])) begin
            dv_rem[k+1][j] <= trial[j] - RW'(dv_ad[k]);
            dv_q[k+1][j]   <= {dv_q[k][j][QB-2:0], 1'b1};
          end else begin
            dv_rem[k+1][j] <= trial[j];
            dv_q[k+1][j]   <= {dv_q[k][j][QB-2:0], 1'b0};
          end
        end
      end
    end
  end

  // round half away from zero, saturate, apply sign
  logic [QB:0]    qinc [0:8];
  logic [QB-1:0]  qr   [0:8];
  m3i_pkg::elem_t res  [0:8];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      qinc[j] = {1'b0, dv_q[QB][j]} + (QB+1)'(1);
      qr[j]   = qinc[j][QB:1];
      if (dv_sing[QB]) begin
        res[j] = '0;
      end else if (!dv_neg[QB][j]) begin
        res[j] = (dv_ovf[QB][j] || qr[j] > QB'(m3i_pkg::SAT_POS)) ?
                 m3i_pkg::SAT_POS : qr[j][EW-1:0];
      end else begin
        res[j] = (dv_ovf[QB][j] || qr[j] > QB'(unsigned'(m3i_pkg::SAT_NEG))) ?
                 m3i_pkg::SAT_NEG : -qr[j][EW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 9; j++) begin
        fin_data[j*EW +: EW] <= res[j];
      end
      fin_sing <= dv_sing[QB];
    end
  end

  // output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      skid_valid    <= 1'b0;
    end else if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tvalid <= 1'b1;
        skid_valid    <= 1'b0;
      end else begin
        m_axis_tvalid <= vfin;
      end
    end else if (vfin) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_axis_tready || !m_axis_tvalid) begin
      if (skid_valid) begin
        m_axis_tdata <= skid_data;
        m_axis_tuser <= skid_sing;
      end else if (vfin) begin
        m_axis_tdata <= fin_data;
        m_axis_tuser <= fin_sing;
      end
    end else if (en && vfin) begin
      skid_data <= fin_data;
      skid_sing <= fin_sing;
    end
  end

`ifndef SYNTHESIS
  a_sing_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
    else $error("singular word with nonzero data");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("skid loaded without a stall");

  a_skid_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_axis_tvalid)
    else $error("skid holds a word while output is empty");

  a_reset_empty: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid && !skid_valid)
    else $error("output not empty after reset");
`endif

endmodule

// File: tb/matrix3x3_inverse_checker.sv
`timescale 1ns / 1ps

module matrix3x3_inverse_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [m3i_pkg::THR_W-1:0]    cfg_wr_data,
  input  logic                         s_axis_tvalid,
  input  logic                         s_axis_tready,
  input  logic [m3i_pkg::DATA_W-1:0]   s_axis_tdata,
  input  logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  input  logic [m3i_pkg::DATA_W-1:0]   m_axis_tdata,
  input  logic                         m_axis_tuser,
  output int                           fail_count,
  output int                           inverses_pending,
  output int                           inverses_checked,
  output int                           singular_checked
);
  import m3i_pkg::*;

  localparam int unsigned FB = FRAC_BITS_DEF;

  typedef struct {
    logic [DATA_W-1:0] inv;
    logic              singular;
  } inverse_t;

  inverse_t          inverse_q[$];
  logic [THR_W-1:0]  min_det;

  // exact rational result, rounded half away from zero, then saturated
  function automatic elem_t round_quotient(logic signed [127:0] c, logic signed [127:0] det);
    logic [127:0] mag_c;
    logic [127:0] mag_d;
    logic [127:0] q;
    logic         neg;
    mag_c = c[127] ? 128'(-c) : 128'(c);
    mag_d = det[127] ? 128'(-det) : 128'(det);
    neg = c[127] != det[127];
    q = ((mag_c << (2 * FB + 1)) + mag_d) / (mag_d << 1);
    if (!neg) return (q > 128'h7FFF_FFFF) ? SAT_POS : elem_t'(q[31:0]);
    return (q > 128'h8000_0000) ? SAT_NEG : elem_t'(-q[31:0]);
  endfunction

  function automatic inverse_t invert_matrix(logic [DATA_W-1:0] w, logic [THR_W-1:0] thr);
    logic signed [127:0] a [9];
    logic signed [127:0] c [9];
    logic signed [127:0] det;
    logic [127:0]        mag_d;
    inverse_t            r;
    for (int k = 0; k < 9; k++) a[k] = elem_t'(w[ELEM_W*k +: ELEM_W]);
    det = a[0]*a[4]*a[8] + a[1]*a[5]*a[6] + a[2]*a[3]*a[7]
        - a[2]*a[4]*a[6] - a[1]*a[3]*a[8] - a[0]*a[5]*a[7];
    mag_d = det[127] ? 128'(-det) : 128'(det);
    r.inv = '0;
    r.singular = (mag_d >> (3 * FB - FB)) <= 128'(thr);
    if (r.singular) return r;
    c[0] = a[4]*a[8] - a[5]*a[7];
    c[1] = a[2]*a[7] - a[1]*a[8];
    c[2] = a[1]*a[5] - a[2]*a[4];
    c[3] = a[5]*a[6] - a[3]*a[8];
    c[4] = a[0]*a[8] - a[2]*a[6];
    c[5] = a[2]*a[3] - a[0]*a[5];
    c[6] = a[3]*a[7] - a[4]*a[6];
    c[7] = a[1]*a[6] - a[0]*a[7];
    c[8] = a[0]*a[4] - a[1]*a[3];
    for (int k = 0; k < 9; k++) r.inv[ELEM_W*k +: ELEM_W] = round_quotient(c[k], det);
    return r;
  endfunction

  always @(posedge clk) begin
    inverse_t e;
    int       errs;
    errs = 0;
    if (rst) begin
      min_det <= '0;
      inverse_q.delete();
      fail_count <= 0;
      inverses_checked <= 0;
      singular_checked <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        inverse_q.push_back(invert_matrix(s_axis_tdata, min_det));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (inverse_q.size() == 0) begin
          $display("%0t: unexpected word inv=%h singular=%b", $time, m_axis_tdata, m_axis_tuser);
          errs = errs + 1;
        end else begin
          e = inverse_q.pop_front();
          inverses_checked <= inverses_checked + 1;
          if (e.singular) singular_checked <= singular_checked + 1;
          for (int k = 0; k < 9; k++)
            if (m_axis_tdata[ELEM_W*k +: ELEM_W] !== e.inv[ELEM_W*k +: ELEM_W]) begin
              $display("%0t: inv_%0d%0d expected %h actual %h", $time, k / 3, k % 3,
                       e.inv[ELEM_W*k +: ELEM_W], m_axis_tdata[ELEM_W*k +: ELEM_W]);
              errs = errs + 1;
            end
          if (m_axis_tuser !== e.singular) begin
            $display("%0t: singular expected %b actual %b", $time, e.singular, m_axis_tuser);
            errs = errs + 1;
          end
        end
      end
      fail_count <= fail_count + errs;
      if (cfg_wr_en) min_det <= cfg_wr_data;
    end
    inverses_pending <= inverse_q.size();
  end

endmodule

// File: tb/matrix3x3_inverse_unit_test.sv
`timescale 1ns / 1ps

module matrix3x3_inverse_unit_test;
  import m3i_pkg::*;

  localparam int LATENCY     = 43;
  localparam int STALL_LIMIT = 5000;  // cycles with no word moving and no threshold write

  logic                 clk;
  logic                 rst;
  logic                 cfg_wr_en;
  logic [THR_W-1:0]     cfg_wr_data;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [DATA_W-1:0]    s_axis_tdata;   // a_00,a_01,..,a_22 from bit 0 up
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [DATA_W-1:0]    m_axis_tdata;   // inv_00,inv_01,..,inv_22 from bit 0 up
  logic                 m_axis_tuser;   // singular

  int fail_count, inverses_pending, inverses_checked, singular_checked;
  int send_idle_pct, recv_idle_pct;
  int quiet_cycles;

  matrix3x3_inverse_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  matrix3x3_inverse_checker inverse_check (
    .clk(clk), .rst(rst),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready), .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .fail_count(fail_count), .inverses_pending(inverses_pending),
    .inverses_checked(inverses_checked), .singular_checked(singular_checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver backpressure, redrawn each cycle at the falling edge
  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // watchdog: nothing moving for too long means the block hung
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic logic [DATA_W-1:0] pack_rows(elem_t r0[3], elem_t r1[3], elem_t r2[3]);
    logic [DATA_W-1:0] w;
    for (int k = 0; k < 3; k++) begin
      w[ELEM_W*k +: ELEM_W]     = r0[k];
      w[ELEM_W*(k+3) +: ELEM_W] = r1[k];
      w[ELEM_W*(k+6) +: ELEM_W] = r2[k];
    end
    return w;
  endfunction

  function automatic logic [DATA_W-1:0] diag_matrix(elem_t d0, elem_t d1, elem_t d2);
    elem_t r0[3], r1[3], r2[3];
    r0 = '{d0, 0, 0};
    r1 = '{0, d1, 0};
    r2 = '{0, 0, d2};
    return pack_rows(r0, r1, r2);
  endfunction

  function automatic logic [DATA_W-1:0] fill_matrix(elem_t v);
    logic [DATA_W-1:0] w;
    for (int k = 0; k < 9; k++) w[ELEM_W*k +: ELEM_W] = v;
    return w;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(4))
      0: return elem_t'($urandom);
      1: return elem_t'(int'($urandom_range(32'h4_0000)) - 32'h2_0000);  // about +-2.0
      2: return elem_t'(int'($urandom_range(32'h80_0000)) - 32'h40_0000); // about +-64.0
      3: return elem_t'(int'($urandom_range(200)) - 100);                 // tiny fractions
      default: begin
        case ($urandom_range(4))
          0: return SAT_POS;
          1: return SAT_NEG;
          2: return 32'sh1_0000;
          3: return -32'sh1_0000;
          default: return 0;
        endcase
      end
    endcase
  endfunction

  // random matrices, some diagonally dominant and some with dependent rows
  function automatic logic [DATA_W-1:0] rand_matrix();
    logic [DATA_W-1:0] w;
    int s;
    for (int k = 0; k < 9; k++) w[ELEM_W*k +: ELEM_W] = rand_elem();
    case ($urandom_range(5))
      0: begin  // row 2 = row 0 / 2 + row 1 / 2, singular up to truncation
        for (int k = 0; k < 3; k++)
          w[ELEM_W*(k+6) +: ELEM_W] = elem_t'(w[ELEM_W*k +: ELEM_W]) / 2
                                    + elem_t'(w[ELEM_W*(k+3) +: ELEM_W]) / 2;
      end
      1: begin  // diagonally dominant
        for (int k = 0; k < 9; k++)
          w[ELEM_W*k +: ELEM_W] = elem_t'(int'($urandom_range(32'h2_0000)) - 32'h1_0000);
        for (int k = 0; k < 3; k++) begin
          s = $urandom_range(1) ? 1 : -1;
          w[ELEM_W*(4*k) +: ELEM_W] = elem_t'(s * int'($urandom_range(32'h40_0000, 32'h8_0000)));
        end
      end
      2: begin  // full random bits everywhere
        for (int k = 0; k < 9; k++) w[ELEM_W*k +: ELEM_W] = $urandom;
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_matrix(logic [DATA_W-1:0] w);
    @(negedge clk);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // drop valid and wait until every inverse is back and the pipeline is empty
  task automatic drain_pipeline();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (inverses_pending != 0) @(negedge clk);
    repeat (LATENCY + 10) @(negedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] thr);
    drain_pipeline();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= thr;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++) begin
      send_matrix(rand_matrix());
      if (i == count / 2) drain_pipeline();  // sender holds off until all is back
    end
  endtask

  initial begin
    logic [DATA_W-1:0] directed [$];
    elem_t r0[3], r1[3], r2[3];
    rst           = 1'b1;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    send_idle_pct = 6;
    recv_idle_pct = 86;
    quiet_cycles  = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: identity, zero, extremes, one-LSB determinants, rounding
    directed.push_back(diag_matrix(32'sh1_0000, 32'sh1_0000, 32'sh1_0000));
    directed.push_back('0);
    directed.push_back(fill_matrix(SAT_POS));
    directed.push_back(fill_matrix(SAT_NEG));
    directed.push_back(diag_matrix(SAT_POS, SAT_POS, SAT_POS));
    directed.push_back(diag_matrix(SAT_NEG, SAT_NEG, SAT_NEG));
    directed.push_back(diag_matrix(SAT_NEG, SAT_POS, -32'sh1_0000));
    directed.push_back(diag_matrix(1, 1, 32'sh1_0000));                // |det| under one LSB
    directed.push_back(diag_matrix(32'sh1_0000, 32'sh1_0000, 1));      // det one LSB, saturates
    directed.push_back(diag_matrix(-32'sh1_0000, 32'sh1_0000, 1));     // negative det, positive saturation
    directed.push_back(diag_matrix(2, 2, 2));                          // |det| under one LSB, singular
    directed.push_back(diag_matrix(-2, 2, 2));                         // negative det, |det| under one LSB, singular
    directed.push_back(diag_matrix(32'sh3_0000, 32'sh3_0000, 32'sh3_0000)); // 1/3 rounding
    directed.push_back(diag_matrix(32'sh2_0000, -32'sh4_0000, 32'sh0_8000));
    directed.push_back(diag_matrix(32'sh6_0000, 32'sh6_0000, 32'sh1_0000)); // 1/6 rounding
    r0 = '{32'sh1_0000, 32'sh2_0000, 32'sh3_0000};
    r1 = '{32'sh4_0000, 32'sh5_0000, 32'sh6_0000};
    r2 = '{32'sh7_0000, 32'sh8_0000, 32'sh9_0000};
    directed.push_back(pack_rows(r0, r1, r2));                         // singular, rank 2
    r2 = '{32'sh7_0000, 32'sh8_0000, 32'sha_0000};
    directed.push_back(pack_rows(r0, r1, r2));                         // det -3
    r0 = '{0, 32'sh1_0000, 0};
    r1 = '{0, 0, -32'sh1_0000};
    r2 = '{32'sh1_0000, 0, 0};
    directed.push_back(pack_rows(r0, r1, r2));                         // permutation
    directed.push_back({9{32'hFFFF_FFFF}});
    foreach (directed[i]) send_matrix(directed[i]);

    write_threshold(31'd1);
    random_phase(500);
    write_threshold(31'($urandom_range(32'h1_0000)));
    send_idle_pct = 86;
    recv_idle_pct = 6;
    random_phase(500);
    write_threshold(31'h7FFF_FFFF);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(250);
    write_threshold(31'($urandom));
    random_phase(250);
    write_threshold(31'd0);
    random_phase(350);

    drain_pipeline();
    $display("Checked %0d inverses (%0d singular) over five thresholds and three backpressure mixes",
             inverses_checked, singular_checked);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/m3i_pkg.sv
rtl/core/matrix3x3_inverse_unit.sv
tb/matrix3x3_inverse_checker.sv
tb/matrix3x3_inverse_unit_test.sv
